[hw/rtl/hsha_pkg.sv]
// Shared types, constants and helper functions of the HMAC-SHA1 engine.
package hsha_pkg;

    localparam int unsigned KeyRegs    = 8;
    localparam int unsigned DigWords   = 5;
    localparam int unsigned InDepth    = 4;
    localparam int unsigned OutDepth   = 8;
    localparam int unsigned Rounds     = 80;

    localparam logic [31:0] IPAD_WORD  = 32'h3636_3636;
    localparam logic [31:0] OPAD_WORD  = 32'h5c5c_5c5c;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
    localparam logic [31:0] OUTER_BITS = 32'd672;

    localparam logic [31:0] K0 = 32'h5a82_7999;
    localparam logic [31:0] K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K3 = 32'hca62_c1d6;

    localparam logic [DigWords-1:0][31:0] SHA1_IV = {
        32'hc3d2_e1f0, 32'h1032_5476, 32'h98ba_dcfe, 32'hefcd_ab89, 32'h6745_2301
    };

    // One input request.
    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_item;

    // One result request.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_result;

    typedef logic [KeyRegs-1:0][63:0] t_key;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_FINISH, ST_PAD80, ST_PADZ, ST_PADLEN, ST_EMIT
    } t_state;

    // What follows a finished compression.
    typedef enum logic [2:0] {
        CX_KEY_IN, CX_MSG, CX_MSG_LAST, CX_PAD, CX_INNER_LAST, CX_KEY_OUT, CX_OUTER
    } t_ctx;

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] v);
        return {v[1:0], v[31:2]};
    endfunction

endpackage

[hw/rtl/hsha_in_q.sv]
// Front end: drops empty non-final requests and queues the rest for the core.
module hsha_in_q (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  hsha_pkg::t_item i_item,
    output logic            o_valid,
    output hsha_pkg::t_item o_item,
    input  logic            i_take
);
    hsha_pkg::t_item r_mem [hsha_pkg::InDepth];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       w_keep, w_wr, w_rd;

    // A request that carries no byte and ends nothing has no effect.
    assign o_full  = (r_cnt == 3'(hsha_pkg::InDepth));
    assign w_keep  = i_item.byte_present | i_item.end_of_message;
    assign w_wr    = i_push & ~o_full & w_keep;
    assign o_valid = (r_cnt != 3'd0);
    assign w_rd    = i_take & o_valid;
    assign o_item  = r_mem[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wr <= r_wr + 2'd1;
            if (w_rd) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(w_wr) - 3'(w_rd);
        end
    end
endmodule

[hw/rtl/hsha_out_q.sv]
// Result queue between the core and the output port.
module hsha_out_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hsha_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_empty,
    output hsha_pkg::t_result o_result,
    input  logic              i_pop
);
    hsha_pkg::t_result r_mem [hsha_pkg::OutDepth];
    logic [2:0] r_wr, r_rd;
    logic [3:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full   = (r_cnt == 4'(hsha_pkg::OutDepth));
    assign o_empty  = (r_cnt == 4'd0);
    assign w_wr     = i_valid & ~o_full;
    assign w_rd     = i_pop & ~o_empty;
    assign o_result = r_mem[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_result;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wr <= r_wr + 3'd1;
            if (w_rd) r_rd <= r_rd + 3'd1;
            r_cnt <= r_cnt + 4'(w_wr) - 4'(w_rd);
        end
    end
endmodule

[hw/rtl/hsha_core.sv]
// Back end: byte packing, padding, SHA-1 rounds and the HMAC sequence.
module hsha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsha_pkg::t_key    i_key,
    input  logic              i_item_valid,
    input  hsha_pkg::t_item   i_item,
    output logic              o_item_take,
    output logic              o_res_valid,
    output hsha_pkg::t_result o_result,
    input  logic              i_res_full
);
    hsha_pkg::t_state r_state, n_state;
    hsha_pkg::t_ctx   r_ctx, n_ctx;
    logic [511:0] r_blk, n_blk;
    logic [hsha_pkg::DigWords-1:0][31:0] r_h, n_h, r_inner, n_inner, w_sum;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, n_a, n_b, n_c, n_d, n_e;
    logic [6:0]   r_rnd, n_rnd;
    logic [5:0]   r_pos, n_pos;
    logic [63:0]  r_bitcnt, n_bitcnt;
    logic         r_phase, n_phase;
    logic [2:0]   r_wcnt, n_wcnt;
    logic [511:0] w_ipad, w_opad, w_dblk;
    logic [31:0]  w_f, w_k, w_tmp, w_new;

    // Key blocks, the outer message block and the chaining-value sums.
    always_comb begin
        for (int i = 0; i < hsha_pkg::KeyRegs; i++) begin
            w_ipad[511-64*i -: 64] = i_key[i] ^ {hsha_pkg::IPAD_WORD, hsha_pkg::IPAD_WORD};
            w_opad[511-64*i -: 64] = i_key[i] ^ {hsha_pkg::OPAD_WORD, hsha_pkg::OPAD_WORD};
        end
        w_dblk = {r_inner[0], r_inner[1], r_inner[2], r_inner[3], r_inner[4],
                  hsha_pkg::PAD_WORD, 288'd0, hsha_pkg::OUTER_BITS};
        for (int i = 0; i < hsha_pkg::DigWords; i++) begin
            w_sum[i] = r_h[i];
        end
        w_sum[0] = r_h[0] + r_a;
        w_sum[1] = r_h[1] + r_b;
        w_sum[2] = r_h[2] + r_c;
        w_sum[3] = r_h[3] + r_d;
        w_sum[4] = r_h[4] + r_e;
    end

    // One SHA-1 round and the next schedule word.
    always_comb begin
        if (r_rnd < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = hsha_pkg::K0;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = hsha_pkg::K1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = hsha_pkg::K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = hsha_pkg::K3;
        end
        w_tmp = hsha_pkg::rotl5(r_a) + w_f + r_e + r_blk[511:480] + w_k;
        w_new = hsha_pkg::rotl1(r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416]
                                ^ r_blk[511:480]);
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state = r_state;  n_ctx = r_ctx;  n_blk = r_blk;  n_h = r_h;
        n_inner = r_inner;  n_rnd = r_rnd;  n_pos = r_pos;  n_bitcnt = r_bitcnt;
        n_phase = r_phase;  n_wcnt = r_wcnt;
        n_a = r_a;  n_b = r_b;  n_c = r_c;  n_d = r_d;  n_e = r_e;
        o_item_take = 1'b0;
        o_res_valid = 1'b0;
        o_result.digest_word = r_h[r_wcnt];
        o_result.word_number = r_wcnt;
        o_result.last_word   = (r_wcnt == 3'(hsha_pkg::DigWords - 1));
        unique case (r_state)
            hsha_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    if (!r_phase) begin
                        // Start of a message: hash the inner key block first.
                        n_h = hsha_pkg::SHA1_IV;
                        {n_a, n_b, n_c, n_d, n_e} = {hsha_pkg::SHA1_IV[0],
                            hsha_pkg::SHA1_IV[1], hsha_pkg::SHA1_IV[2],
                            hsha_pkg::SHA1_IV[3], hsha_pkg::SHA1_IV[4]};
                        n_blk = w_ipad;  n_rnd = '0;  n_ctx = hsha_pkg::CX_KEY_IN;
                        n_state = hsha_pkg::ST_ROUND;
                    end else begin
                        o_item_take = 1'b1;
                        if (i_item.byte_present) begin
                            n_blk = {r_blk[503:0], i_item.message_byte};
                            n_pos = r_pos + 6'd1;
                            n_bitcnt = r_bitcnt + 64'd8;
                        end
                        if (i_item.byte_present && r_pos == 6'd63) begin
                            {n_a, n_b, n_c, n_d, n_e} = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                            n_rnd = '0;
                            n_ctx = i_item.end_of_message ? hsha_pkg::CX_MSG_LAST
                                                          : hsha_pkg::CX_MSG;
                            n_state = hsha_pkg::ST_ROUND;
                        end else if (i_item.end_of_message) begin
                            n_state = hsha_pkg::ST_PAD80;
                        end
                    end
                end
            end
            hsha_pkg::ST_ROUND: begin
                n_e = r_d;  n_d = r_c;  n_c = hsha_pkg::rotl30(r_b);  n_b = r_a;
                n_a = w_tmp;
                n_blk = {r_blk[479:0], w_new};
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'(hsha_pkg::Rounds - 1)) begin
                    n_state = hsha_pkg::ST_FINISH;
                end
            end
            hsha_pkg::ST_FINISH: begin
                n_h = w_sum;
                n_rnd = '0;
                unique case (r_ctx)
                    hsha_pkg::CX_KEY_IN: begin
                        n_phase = 1'b1;  n_bitcnt = 64'd512;  n_pos = '0;
                        n_state = hsha_pkg::ST_IDLE;
                    end
                    hsha_pkg::CX_MSG:      n_state = hsha_pkg::ST_IDLE;
                    hsha_pkg::CX_MSG_LAST: n_state = hsha_pkg::ST_PAD80;
                    hsha_pkg::CX_PAD:      n_state = hsha_pkg::ST_PADZ;
                    hsha_pkg::CX_INNER_LAST: begin
                        // Inner digest done: start the outer key block.
                        n_inner = w_sum;
                        n_h = hsha_pkg::SHA1_IV;
                        {n_a, n_b, n_c, n_d, n_e} = {hsha_pkg::SHA1_IV[0],
                            hsha_pkg::SHA1_IV[1], hsha_pkg::SHA1_IV[2],
                            hsha_pkg::SHA1_IV[3], hsha_pkg::SHA1_IV[4]};
                        n_blk = w_opad;  n_ctx = hsha_pkg::CX_KEY_OUT;
                        n_state = hsha_pkg::ST_ROUND;
                    end
                    hsha_pkg::CX_KEY_OUT: begin
                        {n_a, n_b, n_c, n_d, n_e} = {w_sum[0], w_sum[1], w_sum[2],
                                                     w_sum[3], w_sum[4]};
                        n_blk = w_dblk;  n_ctx = hsha_pkg::CX_OUTER;
                        n_state = hsha_pkg::ST_ROUND;
                    end
                    hsha_pkg::CX_OUTER: begin
                        n_wcnt = '0;
                        n_state = hsha_pkg::ST_EMIT;
                    end
                    default: n_state = hsha_pkg::ST_IDLE;
                endcase
            end
            hsha_pkg::ST_PAD80: begin
                n_blk = {r_blk[503:0], hsha_pkg::PAD_BYTE};
                n_pos = r_pos + 6'd1;
                if (r_pos == 6'd63) begin
                    {n_a, n_b, n_c, n_d, n_e} = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                    n_ctx = hsha_pkg::CX_PAD;
                    n_state = hsha_pkg::ST_ROUND;
                end else begin
                    n_state = hsha_pkg::ST_PADZ;
                end
            end
            hsha_pkg::ST_PADZ: begin
                if (r_pos == 6'd56) begin
                    n_state = hsha_pkg::ST_PADLEN;
                end else begin
                    n_blk = {r_blk[503:0], 8'd0};
                    n_pos = r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        {n_a, n_b, n_c, n_d, n_e} = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                        n_ctx = hsha_pkg::CX_PAD;
                        n_state = hsha_pkg::ST_ROUND;
                    end
                end
            end
            hsha_pkg::ST_PADLEN: begin
                // Bit count goes out big-endian, one byte a cycle.
                n_blk = {r_blk[503:0], r_bitcnt[63:56]};
                n_bitcnt = {r_bitcnt[55:0], 8'd0};
                n_pos = r_pos + 6'd1;
                if (r_pos == 6'd63) begin
                    {n_a, n_b, n_c, n_d, n_e} = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                    n_ctx = hsha_pkg::CX_INNER_LAST;
                    n_state = hsha_pkg::ST_ROUND;
                end
            end
            hsha_pkg::ST_EMIT: begin
                if (!i_res_full) begin
                    o_res_valid = 1'b1;
                    n_wcnt = r_wcnt + 3'd1;
                    if (r_wcnt == 3'(hsha_pkg::DigWords - 1)) begin
                        n_h = hsha_pkg::SHA1_IV;
                        n_phase = 1'b0;  n_bitcnt = '0;  n_pos = '0;  n_wcnt = '0;
                        n_state = hsha_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = hsha_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hsha_pkg::ST_IDLE;
            r_ctx    <= hsha_pkg::CX_MSG;
            r_h      <= hsha_pkg::SHA1_IV;
            r_rnd    <= '0;
            r_pos    <= '0;
            r_bitcnt <= '0;
            r_phase  <= 1'b0;
            r_wcnt   <= '0;
            r_a <= '0;  r_b <= '0;  r_c <= '0;  r_d <= '0;  r_e <= '0;
        end else begin
            r_state  <= n_state;
            r_ctx    <= n_ctx;
            r_h      <= n_h;
            r_rnd    <= n_rnd;
            r_pos    <= n_pos;
            r_bitcnt <= n_bitcnt;
            r_phase  <= n_phase;
            r_wcnt   <= n_wcnt;
            r_a <= n_a;  r_b <= n_b;  r_c <= n_c;  r_d <= n_d;  r_e <= n_e;
        end
    end

    // Block and inner digest payload.
    always_ff @(posedge i_clk) begin
        r_blk   <= n_blk;
        r_inner <= n_inner;
    end

    // The round counter reaches the round count only in the finish cycle.
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= 7'(hsha_pkg::Rounds))
        else $error("round counter out of range");

    // Results are only offered when the result queue has room.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (!i_res_full && r_state == hsha_pkg::ST_EMIT))
        else $error("result offered without room");

    // Between messages the bit count is cleared.
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hsha_pkg::ST_IDLE && !r_phase) |-> (r_bitcnt == 64'd0))
        else $error("stale bit count between messages");
endmodule

[hw/rtl/hmac_sha1_engine.sv]
// Top level of the HMAC-SHA1 engine: key registers, front queue, core, result queue.
//
// Channel   Direction  Handshake          Carries
// input     in         push / full        message byte, byte flag, end flag
// result    out        pop / empty        digest word, word number, last flag
// config    in         valid / ready      register index, 64-bit key data
//
// The first request of a message waits while the inner key block is hashed.
// Each 64-byte block is packed byte by byte and then hashed in the single
// SHA-1 round unit; no requests are taken while a block is being hashed.
// The final request adds the padding, one or two inner compressions and two
// outer ones (outer key and outer digest block), then the five result words.
// Reset is synchronous; the result queue holds eight words, and the core
// stalls in its result state while that queue is full.
module hmac_sha1_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  hsha_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output hsha_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [3:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data
);
    hsha_pkg::t_key    r_key;
    hsha_pkg::t_item   w_item;
    hsha_pkg::t_result w_res;
    logic              w_item_valid, w_take, w_res_valid, w_res_full;

    // Key registers; indexes past the last register are dropped.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid && !i_cfg_index[3]) begin
            r_key[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    hsha_in_q u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (w_item_valid),
        .o_item  (w_item),
        .i_take  (w_take)
    );

    hsha_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (r_key),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_take),
        .o_res_valid  (w_res_valid),
        .o_result     (w_res),
        .i_res_full   (w_res_full)
    );

    hsha_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_res_valid),
        .i_result (w_res),
        .o_full   (w_res_full),
        .o_empty  (empty),
        .o_result (o_result),
        .i_pop    (pop)
    );
endmodule

[verif/hmac_sha1_engine_test.sv]
// Self-checking testbench for the HMAC-SHA1 engine, with a built-in digest predictor.
module hmac_sha1_engine_test;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    hsha_pkg::t_item   i_item = '0;
    logic              empty;
    logic              pop = 1'b0;
    hsha_pkg::t_result o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [3:0]        i_cfg_index = '0;
    logic [63:0]       i_cfg_data = '0;

    hmac_sha1_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Requests waiting to be offered, and digest words still owed by the block.
    hsha_pkg::t_item   pending_items[$];
    hsha_pkg::t_result digest_words_due[$];

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned error_count = 0;
    int unsigned items_accepted = 0;
    int unsigned words_checked = 0;
    int unsigned messages_sent = 0;
    logic        item_taken = 1'b0;
    logic        key_write_taken = 1'b0;

    // Predictor state: key, chaining value, block buffer, bit count, phase.
    logic [63:0] key_model[hsha_pkg::KeyRegs];
    logic [31:0] chain_h[hsha_pkg::DigWords];
    logic [31:0] block_w[16];
    logic [63:0] msg_bits;
    logic        inner_open;

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = block_w[i];
        for (int i = 16; i < 80; i++)
            w[i] = rot_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5a82_7999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ed9_eba1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8f1b_bcdc;
            end else begin
                f = b ^ c ^ d; k = 32'hca62_c1d6;
            end
            t = rot_left(a, 5) + f + e + w[i] + k;
            e = d; d = c; c = rot_left(b, 30); b = a; a = t;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
    endfunction

    function automatic void hash_key_block(input logic [31:0] pad);
        for (int i = 0; i < hsha_pkg::DigWords; i++) chain_h[i] = hsha_pkg::SHA1_IV[i];
        for (int i = 0; i < 8; i++) begin
            block_w[2*i]   = key_model[i][63:32] ^ pad;
            block_w[2*i+1] = key_model[i][31:0] ^ pad;
        end
        sha1_compress();
    endfunction

    function automatic void put_msg_byte(input int idx, input logic [7:0] b);
        block_w[idx >> 2][8*(3 - (idx & 3)) +: 8] = b;
    endfunction

    // Advances the predictor by one accepted request; a final one yields five words.
    function automatic void predict_digest(input hsha_pkg::t_item it);
        int idx;
        logic [31:0] inner_h[hsha_pkg::DigWords];
        hsha_pkg::t_result r;
        if (!it.byte_present && !it.end_of_message) return;
        if (!inner_open) begin
            hash_key_block(hsha_pkg::IPAD_WORD);
            msg_bits = 64'd512;
            inner_open = 1'b1;
        end
        if (it.byte_present) begin
            idx = int'(msg_bits[8:3]);
            put_msg_byte(idx, it.message_byte);
            msg_bits += 64'd8;
            if (idx == 63) sha1_compress();
        end
        if (!it.end_of_message) return;
        // Inner padding, with an extra block when the length no longer fits.
        idx = int'(msg_bits[8:3]);
        put_msg_byte(idx, 8'h80);
        for (int i = idx + 1; i < 64; i++) put_msg_byte(i, 8'h00);
        if (idx >= 56) begin
            sha1_compress();
            for (int i = 0; i < 16; i++) block_w[i] = '0;
        end
        block_w[14] = msg_bits[63:32];
        block_w[15] = msg_bits[31:0];
        sha1_compress();
        for (int i = 0; i < hsha_pkg::DigWords; i++) inner_h[i] = chain_h[i];
        // Outer hash over the opad key block and the inner digest.
        hash_key_block(hsha_pkg::OPAD_WORD);
        for (int i = 0; i < 16; i++) block_w[i] = '0;
        for (int i = 0; i < hsha_pkg::DigWords; i++) block_w[i] = inner_h[i];
        block_w[5] = 32'h8000_0000;
        block_w[15] = 32'd672;
        sha1_compress();
        for (int i = 0; i < hsha_pkg::DigWords; i++) begin
            r.digest_word = chain_h[i];
            r.word_number = 3'(i);
            r.last_word = (i == hsha_pkg::DigWords - 1);
            digest_words_due.push_back(r);
        end
        for (int i = 0; i < hsha_pkg::DigWords; i++) chain_h[i] = hsha_pkg::SHA1_IV[i];
        msg_bits = '0;
        inner_open = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Sender: offers the next request once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!push || item_taken)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                push <= 1'b1;
                i_item <= pending_items.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Monitor: predicts on accepted requests and checks each result word.
    always @(posedge i_clk) begin
        item_taken <= push && !full;
        key_write_taken <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n && push && !full) begin
            items_accepted++;
            predict_digest(i_item);
        end
        if (i_rst_n && pop && !empty) begin
            if (digest_words_due.size() == 0) begin
                report_mismatch("unexpected digest word", o_result.digest_word, '0);
            end else begin
                hsha_pkg::t_result want;
                want = digest_words_due.pop_front();
                words_checked++;
                if (o_result.digest_word != want.digest_word)
                    report_mismatch("digest_word", o_result.digest_word, want.digest_word);
                if (o_result.word_number != want.word_number)
                    report_mismatch("word_number", 32'(o_result.word_number),
                                    32'(want.word_number));
                if (o_result.last_word != want.last_word)
                    report_mismatch("last_word", 32'(o_result.last_word), 32'(want.last_word));
            end
        end
    end

    task automatic write_key_reg(input logic [3:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!key_write_taken);
        i_cfg_valid <= 1'b0;
        if (idx < hsha_pkg::KeyRegs) key_model[idx] = data;
    endtask

    // Loads a key of the given length in bytes; unused bytes are zero.
    task automatic load_key(input int key_len, input bit all_ones);
        logic [63:0] v;
        for (int r = 0; r < hsha_pkg::KeyRegs; r++) begin
            v = all_ones ? '1 : {$urandom, $urandom};
            for (int b = 0; b < 8; b++)
                if (8*r + b >= key_len) v[8*(7-b) +: 8] = 8'h00;
            write_key_reg(4'(r), v);
        end
    endtask

    task automatic queue_item(input logic [7:0] b, input logic present, input logic last);
        hsha_pkg::t_item it;
        it.message_byte = b;
        it.byte_present = present;
        it.end_of_message = last;
        pending_items.push_back(it);
    endtask

    // One message of random bytes; some end on an empty marker, some carry filler.
    task automatic queue_message(input int len);
        bit empty_end;
        empty_end = (len == 0) || $urandom_range(1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(15) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
            queue_item(8'($urandom), 1'b1, !empty_end && (i == len - 1));
        end
        if (empty_end) queue_item(8'($urandom), 1'b0, 1'b1);
        messages_sent++;
    endtask

    task automatic queue_random_messages(input int byte_budget);
        int total, len;
        int edges[8] = '{0, 1, 55, 56, 57, 63, 64, 119};
        total = 0;
        while (total < byte_budget) begin
            len = ($urandom_range(3) == 0) ? edges[$urandom_range(7)] : $urandom_range(20);
            queue_message(len);
            total += len + 1;
        end
    endtask

    // Waits until every request is taken and every digest word checked.
    task automatic drain();
        wait (pending_items.size() == 0 && !push);
        wait (digest_words_due.size() == 0);
        repeat (400) @(negedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < hsha_pkg::KeyRegs; i++) key_model[i] = '0;
        for (int i = 0; i < hsha_pkg::DigWords; i++) chain_h[i] = hsha_pkg::SHA1_IV[i];
        for (int i = 0; i < 16; i++) block_w[i] = '0;
        msg_bits = '0;
        inner_open = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset key, empty message, extreme bytes, filler, both end styles.
        sender_idle_pct = 25;
        receiver_idle_pct = 65;
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'hff, 1'b1, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b0);
        queue_item(8'ha5, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'h80, 1'b1, 1'b1);
        drain();

        // All-ones key, ignored out-of-range indexes, then random traffic.
        load_key(64, 1'b1);
        write_key_reg(4'd8, {$urandom, $urandom});
        write_key_reg(4'd15, '1);
        queue_message(3);
        queue_random_messages(25);
        drain();

        // Short random key, roles of the two sides swapped.
        sender_idle_pct = 65;
        receiver_idle_pct = 25;
        load_key($urandom_range(1, 20), 1'b0);
        queue_random_messages(25);
        drain();

        // Full random key, no idling, and a long receiver hold-off first.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        load_key(64, 1'b0);
        hold_off_cycles = 2000;
        for (int i = 0; i < 6; i++) queue_message(0);
        queue_random_messages(25);
        drain();

        // All-zero key written explicitly.
        load_key(0, 1'b0);
        queue_random_messages(10);
        drain();

        $display("Covered %0d messages in %0d requests, %0d digest words checked,",
                 messages_sent, items_accepted, words_checked);
        $display("under zero, all-ones, short and full keys with varied stalls.");
        if (error_count == 0) begin
            $display("hmac_sha1_engine: match");
        end else begin
            $display("hmac_sha1_engine: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4000000;
        $display("Timeout with %0d digest words outstanding", digest_words_due.size());
        $display("hmac_sha1_engine: mismatch");
        $finish;
    end

endmodule
